// ----- rtl/core/cafr_pkg.sv -----
// Package for the CAN frame to ASCII status block.
// Holds shared types, constants and the gear code table; no dependencies.
package cafr_pkg;

  localparam int unsigned IdW     = 11;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BinW    = 24;
  localparam int unsigned NumDig  = 6;
  localparam int unsigned BcdW    = 4 * NumDig;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [BinW-1:0]  OdoMax   = 24'd999999;
  localparam logic [7:0]       CharZero = 8'h30;
  localparam logic [7:0]       CharOne  = 8'h31;
  localparam logic [7:0]       CharBad  = 8'h39;
  localparam logic [7:0]       BeltMask = 8'h30;
  localparam logic [5:0]       GearMask = 6'h3F;
  localparam logic [CntW-1:0]  ConvSteps = 5'd24;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_ENGINE = 3'd1,
    KIND_GEAR   = 3'd2,
    KIND_BELT   = 3'd3,
    KIND_ODO    = 3'd4
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENGINE_ID = 3'd0,
    REG_GEAR_ID   = 3'd1,
    REG_BELT_ID   = 3'd2,
    REG_ODO_ID    = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_DONE
  } state_t;

  function automatic logic [7:0] gear_char_of(input logic [7:0] b);
    logic [7:0] c;
    case (b[5:0] & GearMask)
      6'h01:   c = 8'h30;
      6'h02:   c = 8'h33;
      6'h04:   c = 8'h31;
      6'h08:   c = 8'h32;
      6'h10:   c = 8'h34;
      6'h20:   c = 8'h35;
      default: c = CharBad;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/cafr_bcd.sv -----
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on cafr_pkg for widths and step count.
module cafr_bcd
  import cafr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [BinW-1:0] value,
  output logic            done,
  output logic [BcdW-1:0] digits
);

  logic [BinW-1:0] bin;
  logic [BcdW-1:0] bcd;
  logic [BcdW-1:0] bcd_adj;
  logic [CntW-1:0] cnt;
  logic            busy;

  always_comb begin
    for (int d = 0; d < NumDig; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ConvSteps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BcdW-2:0], bin[BinW-1]};
      bin <= {bin[BinW-2:0], 1'b0};
    end
  end

  assign digits = bcd;

endmodule

// ----- rtl/core/can_signal_to_ascii_frame.sv -----
// Top level of the CAN frame to ASCII status block.
// Depends on cafr_pkg and cafr_bcd.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one received frame: msg_id
//   and byte0..byte5. Output channel (out_valid / out_stall) carries one
//   status snapshot per frame: matched_kind and the ASCII payload fields.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   writes the four message identifiers; cfg_ready is always high and
//   indexes above three are ignored.
// Processing:
//   Engine and odometer frames run the serial BCD converter, one binary
//   bit per cycle, then wait in S_DONE for the output register.
//   Gear, belt and unmatched frames skip the converter and go to S_DONE.
//   One frame is worked at a time; in_stall is high while it is in work.
// Reset: identifiers take their defaults, held payload characters read
//   '0', output fields load on the first result; no result is pending.
// Stall: the result waits in the output register; a new frame is accepted
//   meanwhile, and its result waits for the register to drain.
module can_signal_to_ascii_frame
  import cafr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IdW-1:0]     msg_id,
  input  logic [ByteW-1:0]   byte0,
  input  logic [ByteW-1:0]   byte1,
  input  logic [ByteW-1:0]   byte2,
  input  logic [ByteW-1:0]   byte3,
  input  logic [ByteW-1:0]   byte4,
  input  logic [ByteW-1:0]   byte5,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         matched_kind,
  output logic [5:0]         door_char,
  output logic [5:0]         brake_char,
  output logic [5:0]         belt_char,
  output logic [23:0]        speed_chars,
  output logic [39:0]        engine_chars,
  output logic [5:0]         gear_char,
  output logic [47:0]        odo_chars,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [IdW-1:0]     cfg_data
);

  logic [IdW-1:0] engine_id, gear_id, belt_id, odo_id;
  state_t state, state_next;
  kind_t  kind, kind_in;
  logic   accept, out_free, conv_start, conv_done;
  logic [BinW-1:0] conv_value, odo_raw;
  logic [BcdW-1:0] conv_digits;
  logic [7:0]  belt_q, gear_q;
  logic [39:0] engine_q;
  logic [47:0] odo_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_id <= 11'd380;
      gear_id   <= 11'd401;
      belt_id   <= 11'd773;
      odo_id    <= 11'd660;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENGINE_ID: engine_id <= cfg_data;
        REG_GEAR_ID:   gear_id   <= cfg_data;
        REG_BELT_ID:   belt_id   <= cfg_data;
        REG_ODO_ID:    odo_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (msg_id == engine_id) begin
      kind_in = KIND_ENGINE;
    end else if (msg_id == gear_id) begin
      kind_in = KIND_GEAR;
    end else if (msg_id == belt_id) begin
      kind_in = KIND_BELT;
    end else if (msg_id == odo_id) begin
      kind_in = KIND_ODO;
    end else begin
      kind_in = KIND_NONE;
    end
  end

  assign odo_raw = {byte3, byte4, byte5};
  always_comb begin
    if (kind_in == KIND_ENGINE) begin
      conv_value = {8'd0, byte2, byte3};
    end else if (odo_raw > OdoMax) begin
      conv_value = OdoMax;
    end else begin
      conv_value = odo_raw;
    end
  end

  assign conv_start = accept && (kind_in == KIND_ENGINE || kind_in == KIND_ODO);

  cafr_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .value  (conv_value),
    .done   (conv_done),
    .digits (conv_digits)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = conv_start ? S_CONV : S_DONE;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind     <= KIND_NONE;
      belt_q   <= CharZero;
      gear_q   <= CharZero;
      engine_q <= {5{CharZero}};
      odo_q    <= {6{CharZero}};
    end else begin
      if (accept) begin
        kind <= kind_in;
        if (kind_in == KIND_GEAR) begin
          gear_q <= gear_char_of(byte0);
        end
        if (kind_in == KIND_BELT) begin
          belt_q <= ((byte1 & BeltMask) != 8'd0) ? CharOne : CharZero;
        end
      end
      if (state == S_CONV && conv_done) begin
        if (kind == KIND_ENGINE) begin
          for (int d = 0; d < 5; d++) begin
            engine_q[8*d +: 8] <= {4'h3, conv_digits[4*d +: 4]};
          end
        end else begin
          for (int d = 0; d < NumDig; d++) begin
            odo_q[8*d +: 8] <= {4'h3, conv_digits[4*d +: 4]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      matched_kind <= kind;
      belt_char    <= belt_q[5:0];
      gear_char    <= gear_q[5:0];
      engine_chars <= engine_q;
      odo_chars    <= odo_q;
    end
  end

  assign door_char   = CharZero[5:0];
  assign brake_char  = CharZero[5:0];
  assign speed_chars = {3{CharZero}};

`ifndef SYNTHESIS
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == S_CONV)
    else $error("converter finished outside conversion");

  a_rose_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised without a finished item");

  a_conv_only_wide: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV |-> (kind == KIND_ENGINE || kind == KIND_ODO))
    else $error("conversion for a kind with no digits");

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> conv_digits[3:0] <= 4'd9 && conv_digits[7:4] <= 4'd9
      && conv_digits[11:8] <= 4'd9 && conv_digits[15:12] <= 4'd9
      && conv_digits[19:16] <= 4'd9 && conv_digits[23:20] <= 4'd9)
    else $error("converter produced a non-decimal digit");
`endif

endmodule
